// ----- rtl/core/min_cost_capacity_allocation_top_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the min-cost capacity allocation block
// Shared property wrappers used by the port checker.
// ---------------------------------------------------------------------------
`ifndef MIN_COST_CAPACITY_ALLOCATION_TOP_ASSERT_SVH
`define MIN_COST_CAPACITY_ALLOCATION_TOP_ASSERT_SVH

// Clocked property that is switched off while reset is asserted.
`define MCCA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset.
`define MCCA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/mcca_pkg.sv -----
// ---------------------------------------------------------------------------
// mcca_pkg
// Sizes, codes and types shared by the min-cost capacity allocation block.
// ---------------------------------------------------------------------------
package mcca_pkg;

    localparam int NUM_CLASSES = 64;
    localparam int MAX_UNITS   = 256;

    localparam int CLS_W   = $clog2(NUM_CLASSES);
    localparam int UNIT_W  = $clog2(MAX_UNITS);
    localparam int ADDR_W  = CLS_W + UNIT_W;
    localparam int COST_W  = 48;
    localparam int SUM_W   = 54;
    localparam int CAP_W   = 8;
    localparam int ALLOC_W = 8;
    localparam int IN_CLS_W = 6;
    localparam int IN_AMT_W = 8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    typedef enum logic [2:0] {
        DP_IDLE = 3'b001,
        DP_RUN  = 3'b010,
        DP_GAP  = 3'b100
    } t_dp_state;

    typedef enum logic [3:0] {
        BT_IDLE = 4'b0001,
        BT_RD   = 4'b0010,
        BT_WAIT = 4'b0100,
        BT_EMIT = 4'b1000
    } t_bt_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [UNIT_W-1:0] data;
    } t_choice_wr;

    typedef struct packed {
        logic               valid;
        logic [CLS_W-1:0]   cls;
        logic [ALLOC_W-1:0] alloc;
        logic               last;
    } t_result;

    function automatic logic [UNIT_W-1:0] sat_cap(input logic [CAP_W-1:0] c);
        if (int'(c) > MAX_UNITS - 1) begin
            return UNIT_W'(MAX_UNITS - 1);
        end
        return UNIT_W'(c);
    endfunction

endpackage

// ----- rtl/core/mcca_ram.sv -----
// ---------------------------------------------------------------------------
// mcca_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module mcca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/mcca_dp.sv -----
// ---------------------------------------------------------------------------
// mcca_dp
// Dynamic-programming sweep: one candidate split per cycle over two best rows, idle gap between classes.
// ---------------------------------------------------------------------------
module mcca_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [mcca_pkg::UNIT_W-1:0]         i_cap,
    output logic                                o_done,
    output logic [mcca_pkg::ADDR_W-1:0]         o_cost_raddr,
    input  logic [mcca_pkg::COST_W-1:0]         i_cost_rdata,
    output mcca_pkg::t_choice_wr                o_choice_wr
);

    mcca_pkg::t_dp_state r_state, n_state;
    logic [mcca_pkg::CLS_W-1:0]  r_i, n_i;
    logic [mcca_pkg::UNIT_W-1:0] r_j, n_j, r_k, n_k;
    logic                        r_v1, r_last1;
    logic [mcca_pkg::UNIT_W-1:0] r_j1, r_k1;
    logic [mcca_pkg::SUM_W-1:0]  r_best, n_best;
    logic [mcca_pkg::UNIT_W-1:0] r_pick, n_pick;

    logic [mcca_pkg::UNIT_W:0]   rows_raddr, rows_waddr;
    logic [mcca_pkg::SUM_W-1:0]  rows_rdata, prev_val, cand;
    logic                        rows_we, take, issue;

    mcca_ram #(
        .WIDTH(mcca_pkg::SUM_W),
        .DEPTH(2 * mcca_pkg::MAX_UNITS)
    ) u_rows (
        .i_clk  (i_clk),
        .i_we   (rows_we),
        .i_waddr(rows_waddr),
        .i_wdata(n_best),
        .i_raddr(rows_raddr),
        .o_rdata(rows_rdata)
    );

    // Class i reads the row of class i-1 (other parity) and writes its own.
    assign rows_raddr   = {~r_i[0], r_j - r_k};
    assign o_cost_raddr = {r_i, r_k};
    assign issue        = (r_state == mcca_pkg::DP_RUN);

    // Class 1 builds on the all-zero row of class 0.
    assign prev_val = (r_i == mcca_pkg::CLS_W'(1)) ? '0 : rows_rdata;
    assign cand     = prev_val + mcca_pkg::SUM_W'(i_cost_rdata);
    assign take     = (r_k1 == '0) || (cand < r_best);
    assign n_best   = take ? cand : r_best;
    assign n_pick   = take ? r_k1 : r_pick;

    assign rows_we    = r_v1 && r_last1;
    assign rows_waddr = {r_i[0], r_j1};

    assign o_choice_wr.we   = rows_we;
    assign o_choice_wr.addr = {r_i, r_j1};
    assign o_choice_wr.data = n_pick;

    assign o_done = (r_state == mcca_pkg::DP_GAP) &&
                    (r_i == mcca_pkg::CLS_W'(mcca_pkg::NUM_CLASSES - 1));

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        case (r_state)
            mcca_pkg::DP_IDLE: begin
                if (i_start) begin
                    n_state = mcca_pkg::DP_RUN;
                    n_i     = mcca_pkg::CLS_W'(1);
                    n_j     = '0;
                    n_k     = '0;
                end
            end
            mcca_pkg::DP_RUN: begin
                if (r_k == r_j) begin
                    n_k = '0;
                    if (r_j == i_cap) begin
                        n_state = mcca_pkg::DP_GAP;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            mcca_pkg::DP_GAP: begin
                // The idle gap state lets the last write of a row land before the
                // next class reads it.
                n_j = '0;
                n_k = '0;
                if (o_done) begin
                    n_state = mcca_pkg::DP_IDLE;
                end else begin
                    n_state = mcca_pkg::DP_RUN;
                    n_i     = r_i + 1'b1;
                end
            end
            default: begin
                n_state = mcca_pkg::DP_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcca_pkg::DP_IDLE;
            r_v1    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_j1    <= r_j;
        r_k1    <= r_k;
        r_last1 <= (r_k == r_j);
        if (r_v1) begin
            r_best <= n_best;
            r_pick <= n_pick;
        end
    end

endmodule

// ----- rtl/core/mcca_bt.sv -----
// ---------------------------------------------------------------------------
// mcca_bt
// Backtrack through the choice table, then emit allocations in class order.
// ---------------------------------------------------------------------------
module mcca_bt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [mcca_pkg::UNIT_W-1:0]  i_cap,
    output logic [mcca_pkg::ADDR_W-1:0]  o_choice_raddr,
    input  logic [mcca_pkg::UNIT_W-1:0]  i_choice_rdata,
    output mcca_pkg::t_result            o_result
);

    mcca_pkg::t_bt_state r_state, n_state;
    logic [mcca_pkg::CLS_W-1:0]  r_i, n_i, r_e, n_e, r_oc;
    logic [mcca_pkg::UNIT_W-1:0] r_rem, n_rem;
    logic                        r_ov, r_ol;
    logic                        alloc_we;
    logic [mcca_pkg::UNIT_W-1:0] alloc_rdata;

    mcca_ram #(
        .WIDTH(mcca_pkg::UNIT_W),
        .DEPTH(mcca_pkg::NUM_CLASSES)
    ) u_alloc (
        .i_clk  (i_clk),
        .i_we   (alloc_we),
        .i_waddr(r_i),
        .i_wdata(i_choice_rdata),
        .i_raddr(r_e),
        .o_rdata(alloc_rdata)
    );

    assign o_choice_raddr = {r_i, r_rem};
    assign alloc_we       = (r_state == mcca_pkg::BT_WAIT);

    assign o_result.valid = r_ov;
    assign o_result.cls   = r_oc;
    assign o_result.alloc = (r_oc == '0) ? '0 : mcca_pkg::ALLOC_W'(alloc_rdata);
    assign o_result.last  = r_ol;

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_e     = r_e;
        n_rem   = r_rem;
        case (r_state)
            mcca_pkg::BT_IDLE: begin
                if (i_start) begin
                    n_state = mcca_pkg::BT_RD;
                    n_i     = mcca_pkg::CLS_W'(mcca_pkg::NUM_CLASSES - 1);
                    n_rem   = i_cap;
                end
            end
            mcca_pkg::BT_RD: begin
                n_state = mcca_pkg::BT_WAIT;
            end
            mcca_pkg::BT_WAIT: begin
                n_rem = r_rem - i_choice_rdata;
                if (r_i == mcca_pkg::CLS_W'(1)) begin
                    n_state = mcca_pkg::BT_EMIT;
                    n_e     = '0;
                end else begin
                    n_state = mcca_pkg::BT_RD;
                    n_i     = r_i - 1'b1;
                end
            end
            mcca_pkg::BT_EMIT: begin
                if (r_e == mcca_pkg::CLS_W'(mcca_pkg::NUM_CLASSES - 1)) begin
                    n_state = mcca_pkg::BT_IDLE;
                end else begin
                    n_e = r_e + 1'b1;
                end
            end
            default: begin
                n_state = mcca_pkg::BT_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcca_pkg::BT_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= (r_state == mcca_pkg::BT_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        r_i   <= n_i;
        r_e   <= n_e;
        r_rem <= n_rem;
        r_oc  <= r_e;
        r_ol  <= (r_e == mcca_pkg::CLS_W'(mcca_pkg::NUM_CLASSES - 1));
    end

endmodule

// ----- rtl/core/min_cost_capacity_allocation_top.sv -----
// A load request yields no result; loads may follow back to back while busy is low.
// A run request first sweeps the table for capacity C, one candidate split tried
// per cycle with an idle gap between classes, then backtracks (one choice-table
// read and subtract per class) and finally emits the results.
// The 64 results come on consecutive cycles; busy is high from the run until the last.
// Reset is synchronous and active low; cost and scratch memories are not cleared.
// ---------------------------------------------------------------------------
// min_cost_capacity_allocation_top
// Loads per-class cost entries and splits the capacity at least total cost.
// ---------------------------------------------------------------------------
module min_cost_capacity_allocation_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mcca_pkg::CAP_W-1:0]     i_cfg_capacity,
    input  logic                           i_operation,
    input  logic [mcca_pkg::IN_CLS_W-1:0]  i_class_index,
    input  logic [mcca_pkg::IN_AMT_W-1:0]  i_amount,
    input  logic [mcca_pkg::COST_W-1:0]    i_cost_value,
    output logic                           o_valid,
    output logic [5:0]                     o_result_class,
    output logic [mcca_pkg::ALLOC_W-1:0]   o_allocated,
    output logic                           o_last
);

    logic [mcca_pkg::CAP_W-1:0]  r_cap;
    logic [mcca_pkg::UNIT_W-1:0] r_run_cap;
    logic                        r_busy;

    logic                        accept, run_req, load_we, dp_done;
    logic [mcca_pkg::ADDR_W-1:0] load_addr, cost_raddr, choice_raddr;
    logic [mcca_pkg::COST_W-1:0] cost_rdata;
    logic [mcca_pkg::UNIT_W-1:0] choice_rdata;
    mcca_pkg::t_choice_wr        choice_wr;
    mcca_pkg::t_result           result;

    assign accept  = start && !r_busy;
    assign run_req = accept && (i_operation == mcca_pkg::OP_RUN);
    // Out-of-range loads are dropped.
    assign load_we = accept && (i_operation == mcca_pkg::OP_LOAD) &&
                     (int'(i_class_index) < mcca_pkg::NUM_CLASSES) &&
                     (int'(i_amount) < mcca_pkg::MAX_UNITS);
    assign load_addr = {mcca_pkg::CLS_W'(i_class_index), mcca_pkg::UNIT_W'(i_amount)};

    mcca_ram #(
        .WIDTH(mcca_pkg::COST_W),
        .DEPTH(mcca_pkg::NUM_CLASSES * mcca_pkg::MAX_UNITS)
    ) u_cost (
        .i_clk  (i_clk),
        .i_we   (load_we),
        .i_waddr(load_addr),
        .i_wdata(i_cost_value),
        .i_raddr(cost_raddr),
        .o_rdata(cost_rdata)
    );

    mcca_ram #(
        .WIDTH(mcca_pkg::UNIT_W),
        .DEPTH(mcca_pkg::NUM_CLASSES * mcca_pkg::MAX_UNITS)
    ) u_choice (
        .i_clk  (i_clk),
        .i_we   (choice_wr.we),
        .i_waddr(choice_wr.addr),
        .i_wdata(choice_wr.data),
        .i_raddr(choice_raddr),
        .o_rdata(choice_rdata)
    );

    mcca_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (run_req),
        .i_cap       (r_run_cap),
        .o_done      (dp_done),
        .o_cost_raddr(cost_raddr),
        .i_cost_rdata(cost_rdata),
        .o_choice_wr (choice_wr)
    );

    mcca_bt u_bt (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (dp_done),
        .i_cap         (r_run_cap),
        .o_choice_raddr(choice_raddr),
        .i_choice_rdata(choice_rdata),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= '0;
            r_busy <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_capacity;
            end
            if (run_req) begin
                r_busy <= 1'b1;
            end else if (result.valid && result.last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (run_req) begin
            r_run_cap <= mcca_pkg::sat_cap(r_cap);
        end
    end

    assign busy           = r_busy;
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = result.valid;
    assign o_result_class = 6'(result.cls);
    assign o_allocated    = result.alloc;
    assign o_last         = result.last;

endmodule

// ----- rtl/core/min_cost_capacity_allocation_top_chk.sv -----
// ---------------------------------------------------------------------------
// min_cost_capacity_allocation_top_chk
// Port-level checks on run and result sequencing, bound to the top level.
// ---------------------------------------------------------------------------
`include "min_cost_capacity_allocation_top_assert.svh"

module min_cost_capacity_allocation_top_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       i_operation,
    input logic       o_valid,
    input logic [5:0] o_result_class,
    input logic [7:0] o_allocated,
    input logic       o_last
);

    `MCCA_ASSERT(a_result_while_busy, i_clk, i_rst_n, o_valid |-> busy, "result while not busy")
    `MCCA_ASSERT(a_run_sets_busy, i_clk, i_rst_n, start && !busy && i_operation |=> busy, "run request did not raise busy")
    `MCCA_ASSERT(a_results_contiguous, i_clk, i_rst_n, o_valid && !o_last |=> o_valid && (o_result_class == 6'($past(o_result_class) + 6'd1)), "result sequence broken")
    `MCCA_ASSERT(a_class_zero_empty, i_clk, i_rst_n, o_valid && (o_result_class == 6'd0) |-> (o_allocated == 8'd0), "class zero got units")
    `MCCA_ASSERT(a_last_ends_run, i_clk, i_rst_n, o_valid && o_last |=> !o_valid && !busy, "run did not end after last result")

endmodule

bind min_cost_capacity_allocation_top min_cost_capacity_allocation_top_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_operation   (i_operation),
    .o_valid       (o_valid),
    .o_result_class(o_result_class),
    .o_allocated   (o_allocated),
    .o_last        (o_last)
);

// ----- bench/tb_min_cost_capacity_allocation_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Min-cost capacity allocation regression
// Fills the cost table through load requests and starts allocation runs at
// several capacities, predicting every per-class allocation in the bench.
// ---------------------------------------------------------------------------
module tb_min_cost_capacity_allocation_top;

    typedef struct {
        logic                          op;
        logic [mcca_pkg::IN_CLS_W-1:0] cls;
        logic [mcca_pkg::IN_AMT_W-1:0] amt;
        logic [mcca_pkg::COST_W-1:0]   cost;
    } t_request;

    typedef struct {
        logic [5:0]                   cls;
        logic [mcca_pkg::ALLOC_W-1:0] alloc;
        logic                         last;
    } t_alloc;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [mcca_pkg::CAP_W-1:0]    i_cfg_capacity = '0;
    logic                          i_operation = mcca_pkg::OP_LOAD;
    logic [mcca_pkg::IN_CLS_W-1:0] i_class_index = '0;
    logic [mcca_pkg::IN_AMT_W-1:0] i_amount = '0;
    logic [mcca_pkg::COST_W-1:0]   i_cost_value = '0;
    logic                          o_valid;
    logic [5:0]                    o_result_class;
    logic [mcca_pkg::ALLOC_W-1:0]  o_allocated;
    logic                          o_last;

    min_cost_capacity_allocation_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_capacity (i_cfg_capacity),
        .i_operation    (i_operation),
        .i_class_index  (i_class_index),
        .i_amount       (i_amount),
        .i_cost_value   (i_cost_value),
        .o_valid        (o_valid),
        .o_result_class (o_result_class),
        .o_allocated    (o_allocated),
        .o_last         (o_last)
    );

    always #6 i_clk = ~i_clk;

    // Bench copy of the block state.
    logic [mcca_pkg::COST_W-1:0] unit_cost [mcca_pkg::NUM_CLASSES][mcca_pkg::MAX_UNITS];
    logic [mcca_pkg::SUM_W-1:0]  best_row  [2][mcca_pkg::MAX_UNITS];
    logic [mcca_pkg::UNIT_W-1:0] pick_tab  [mcca_pkg::NUM_CLASSES][mcca_pkg::MAX_UNITS];
    logic [mcca_pkg::CAP_W-1:0]  cur_capacity = '0;
    bit                          queued_load [mcca_pkg::NUM_CLASSES][mcca_pkg::MAX_UNITS];

    t_request pending_reqs[$];
    t_alloc   expected_allocs[$];
    t_request held_req;

    int n_errors = 0;
    int n_loads = 0;
    int n_runs = 0;
    int n_checked = 0;
    int burst_left = 0;
    int gap_left = 0;

    task automatic report_mismatch(input string what);
        n_errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Dynamic program over two rolling rows, then backtrack from full capacity.
    task automatic predict_allocation(input logic [mcca_pkg::CAP_W-1:0] cap_in);
        int cap;
        int p;
        int c;
        logic [mcca_pkg::SUM_W-1:0] best;
        logic [mcca_pkg::SUM_W-1:0] trial;
        logic [mcca_pkg::UNIT_W-1:0] pick;
        int rem;
        logic [mcca_pkg::ALLOC_W-1:0] share [mcca_pkg::NUM_CLASSES];
        t_alloc e;
        cap = (int'(cap_in) > mcca_pkg::MAX_UNITS - 1) ? mcca_pkg::MAX_UNITS - 1
                                                       : int'(cap_in);
        p = 0;
        c = 1;
        for (int j = 0; j <= cap; j++) best_row[0][j] = '0;
        for (int i = 1; i < mcca_pkg::NUM_CLASSES; i++) begin
            best_row[c][0] = best_row[p][0] + unit_cost[i][0];
            pick_tab[i][0] = '0;
            for (int j = 1; j <= cap; j++) begin
                best = '1;
                pick = '0;
                for (int k = 0; k <= j; k++) begin
                    trial = best_row[p][j-k] + unit_cost[i][k];
                    // Strict compare keeps the smallest split on ties.
                    if (trial < best) begin
                        best = trial;
                        pick = mcca_pkg::UNIT_W'(k);
                    end
                end
                best_row[c][j] = best;
                pick_tab[i][j] = pick;
            end
            p = c;
            c = 1 - c;
        end
        rem = cap;
        share[0] = '0;
        for (int i = mcca_pkg::NUM_CLASSES - 1; i >= 1; i--) begin
            share[i] = pick_tab[i][rem];
            rem -= int'(share[i]);
        end
        for (int i = 0; i < mcca_pkg::NUM_CLASSES; i++) begin
            e.cls = 6'(i);
            e.alloc = share[i];
            e.last = (i == mcca_pkg::NUM_CLASSES - 1);
            expected_allocs.push_back(e);
        end
    endtask

    // Driver: bursts of requests with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                if (held_req.op == mcca_pkg::OP_LOAD) begin
                    unit_cost[held_req.cls][held_req.amt] = held_req.cost;
                    n_loads++;
                end else begin
                    predict_allocation(cur_capacity);
                    n_runs++;
                end
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    held_req = pending_reqs.pop_front();
                    i_operation   <= held_req.op;
                    i_class_index <= held_req.cls;
                    i_amount      <= held_req.amt;
                    i_cost_value  <= held_req.cost;
                    start <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 20);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_alloc e;
        if (i_rst_n && o_valid) begin
            if (expected_allocs.size() == 0) begin
                report_mismatch($sformatf("unexpected result class %0d", o_result_class));
            end else begin
                e = expected_allocs.pop_front();
                n_checked++;
                if (o_result_class !== e.cls)
                    report_mismatch($sformatf("class %0d, expected %0d",
                                              o_result_class, e.cls));
                if (o_allocated !== e.alloc)
                    report_mismatch($sformatf("class %0d allocated %0d, expected %0d",
                                              e.cls, o_allocated, e.alloc));
                if (o_last !== e.last)
                    report_mismatch($sformatf("class %0d last %0b, expected %0b",
                                              e.cls, o_last, e.last));
            end
        end
    end

    function automatic logic [mcca_pkg::COST_W-1:0] random_cost();
        case ($urandom_range(0, 3))
            0, 1: return mcca_pkg::COST_W'($urandom_range(0, 7));
            2: return mcca_pkg::COST_W'($urandom_range(0, 1000));
            default: return {16'($urandom), 32'($urandom)};
        endcase
    endfunction

    task automatic push_load(input int cls, input int amt,
                             input logic [mcca_pkg::COST_W-1:0] cost);
        t_request r;
        r.op = mcca_pkg::OP_LOAD;
        r.cls = mcca_pkg::IN_CLS_W'(cls);
        r.amt = mcca_pkg::IN_AMT_W'(amt);
        r.cost = cost;
        queued_load[cls][amt] = 1'b1;
        pending_reqs.push_back(r);
    endtask

    // A run may only read entries that were loaded, so missing ones go first.
    task automatic push_run(input int cap);
        t_request r;
        for (int i = 1; i < mcca_pkg::NUM_CLASSES; i++)
            for (int k = 0; k <= cap; k++)
                if (!queued_load[i][k]) push_load(i, k, random_cost());
        r.op = mcca_pkg::OP_RUN;
        r.cls = mcca_pkg::IN_CLS_W'($urandom);
        r.amt = mcca_pkg::IN_AMT_W'($urandom);
        r.cost = {16'($urandom), 32'($urandom)};
        pending_reqs.push_back(r);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || start || expected_allocs.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_capacity(input int cap);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_capacity <= mcca_pkg::CAP_W'(cap);
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        cur_capacity = mcca_pkg::CAP_W'(cap);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int cap, input int n);
        for (int n_req = 0; n_req < n; n_req++) begin
            if ($urandom_range(0, 6) == 0) begin
                push_run(cap);
            end else if ($urandom_range(0, 2) == 0) begin
                push_load($urandom_range(0, 63), $urandom_range(0, 255), random_cost());
            end else begin
                push_load($urandom_range(1, 63), $urandom_range(0, cap), random_cost());
            end
        end
        push_run(cap);
    endtask

    initial begin
        int caps [5] = '{1, 3, 2, 0, 3};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: capacity zero, cost extremes, the edge classes and amounts.
        write_capacity(0);
        push_load(0, 0, '1);
        push_load(63, 255, '1);
        push_load(63, 0, '0);
        push_load(1, 0, '1);
        push_load(0, 255, 48'hAAAA_AAAA_AAAA);
        push_load(32, 128, 48'h5555_5555_5555);
        push_run(0);
        // All-zero costs: every split ties, the smallest share must win.
        write_capacity(2);
        for (int i = 1; i < mcca_pkg::NUM_CLASSES; i++)
            for (int k = 0; k <= 2; k++) push_load(i, k, '0);
        push_run(2);
        // Reload class 7 amount 2 at zero cost and make amount zero cost 5 on classes 1 through 63.
        push_load(7, 2, '0);
        for (int i = 1; i < mcca_pkg::NUM_CLASSES; i++) push_load(i, 0, 48'd5);
        push_run(2);

        foreach (caps[n]) begin
            write_capacity(caps[n]);
            random_phase(caps[n], 14);
        end
        wait_idle();
        repeat (200) @(posedge i_clk);

        $display("Covered %0d loads and %0d allocation runs, %0d results checked,",
                 n_loads, n_runs, n_checked);
        $display("at capacities 0 through 3.");
        if (n_errors == 0 && expected_allocs.size() == 0) begin
            $display("min_cost_capacity_allocation_top regression: pass");
        end else begin
            $display("min_cost_capacity_allocation_top regression: fail");
        end
        $finish;
    end

    initial begin
        #(12.0 * 12_000_000);
        $display("min_cost_capacity_allocation_top regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/mcca_pkg.sv
rtl/core/mcca_ram.sv
rtl/core/mcca_dp.sv
rtl/core/mcca_bt.sv
rtl/core/min_cost_capacity_allocation_top.sv
rtl/core/min_cost_capacity_allocation_top_chk.sv
bench/tb_min_cost_capacity_allocation_top.sv
